// ===== rtl/bcc_pkg.sv =====
// Shared types and constants for the balance cascade controller.
package bcc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [31:0] RST_UPRIGHT_KP    = -32'sd32768000;
  localparam logic signed [31:0] RST_UPRIGHT_KD    = -32'sd125829;
  localparam logic signed [31:0] RST_SPEED_KP      = -32'sd28836;
  localparam logic signed [31:0] RST_SPEED_KI      = -32'sd144;
  localparam logic signed [31:0] RST_STEER_KP      = 32'sd1310720;
  localparam logic signed [31:0] RST_STEER_DAMPING = 32'sd39322;
  localparam logic signed [16:0] RST_BALANCE_ANGLE = 17'sd128;
  localparam logic [14:0]        RST_MOTOR_LIMIT   = 15'd7000;

  localparam logic signed [15:0] INTEGRAL_LIMIT = 16'sd20000;
  localparam logic [15:0]        AVOID_MIN_SIZE = 16'd200;
  localparam logic [7:0]         LINE_MIN_CONF  = 8'd10;

  localparam logic signed [4:0] TARGET_AVOID = -5'sd10;
  localparam logic signed [4:0] TARGET_SLOW  = -5'sd5;
  localparam logic signed [4:0] TARGET_NONE  = 5'sd0;
  localparam logic signed [6:0] TURN_HARD    = 7'sd45;
  localparam logic signed [6:0] TURN_OTHER   = -7'sd30;

  localparam logic signed [21:0] LINE_N_LIMIT = 22'sd10000;

  // x/10 = (x * RECIP_10) >> 24 for x < 2^22; x/100 = (x * RECIP_100) >> 21 for x < 2^15
  localparam logic signed [31:0] RECIP_10  = 32'sd1677722;
  localparam logic signed [31:0] RECIP_100 = 32'sd20972;

  typedef enum logic [2:0] {
    REG_UPRIGHT_KP    = 3'd0,
    REG_UPRIGHT_KD    = 3'd1,
    REG_SPEED_KP      = 3'd2,
    REG_SPEED_KI      = 3'd3,
    REG_STEER_KP      = 3'd4,
    REG_STEER_DAMPING = 3'd5,
    REG_BALANCE_ANGLE = 3'd6,
    REG_MOTOR_LIMIT   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    COLOR_NONE  = 2'd0,
    COLOR_LEFT  = 2'd1,
    COLOR_RIGHT = 2'd2,
    COLOR_OTHER = 2'd3
  } color_e;

  typedef enum logic [1:0] {
    MODE_BALANCE = 2'd0,
    MODE_LINE    = 2'd1,
    MODE_AVOID   = 2'd2
  } drive_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FE_NUM, ST_FE_MUL, ST_FE_SET, ST_SI_SET, ST_SP_MUL2, ST_SP_SUM, ST_SP_SET,
    ST_D_SET, ST_UP_MUL1, ST_UP_MUL2, ST_UP_SUM, ST_UP_SET, ST_ST_MUL, ST_ST_SET, ST_MIX
  } state_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_FE_NUM, OP_FE_MUL, OP_FE_SET, OP_SI_SET, OP_SP_MUL2, OP_SP_SUM,
    OP_SP_SET, OP_D_SET, OP_UP_MUL1, OP_UP_MUL2, OP_UP_SUM, OP_UP_SET, OP_ST_MUL,
    OP_ST_SET, OP_MIX
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] upright_kp;
    logic signed [31:0] upright_kd;
    logic signed [31:0] speed_kp;
    logic signed [31:0] speed_ki;
    logic signed [31:0] steer_kp;
    logic signed [31:0] steer_damping;
    logic signed [16:0] balance_angle;
    logic [14:0]        motor_limit;
  } cfg_t;

endpackage

// ===== rtl/bcc_regs.sv =====
// Configuration register file for the balance cascade controller.
module bcc_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bcc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output bcc_pkg::cfg_t                   cfg_o
);
  import bcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_UPRIGHT_KP:    cfg_d.upright_kp    = $signed(cfg_wdata_i[31:0]);
        REG_UPRIGHT_KD:    cfg_d.upright_kd    = $signed(cfg_wdata_i[31:0]);
        REG_SPEED_KP:      cfg_d.speed_kp      = $signed(cfg_wdata_i[31:0]);
        REG_SPEED_KI:      cfg_d.speed_ki      = $signed(cfg_wdata_i[31:0]);
        REG_STEER_KP:      cfg_d.steer_kp      = $signed(cfg_wdata_i[31:0]);
        REG_STEER_DAMPING: cfg_d.steer_damping = $signed(cfg_wdata_i[31:0]);
        REG_BALANCE_ANGLE: cfg_d.balance_angle = $signed(cfg_wdata_i[16:0]);
        REG_MOTOR_LIMIT:   cfg_d.motor_limit   = cfg_wdata_i[14:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upright_kp    <= RST_UPRIGHT_KP;
      cfg_q.upright_kd    <= RST_UPRIGHT_KD;
      cfg_q.speed_kp      <= RST_SPEED_KP;
      cfg_q.speed_ki      <= RST_SPEED_KI;
      cfg_q.steer_kp      <= RST_STEER_KP;
      cfg_q.steer_damping <= RST_STEER_DAMPING;
      cfg_q.balance_angle <= RST_BALANCE_ANGLE;
      cfg_q.motor_limit   <= RST_MOTOR_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bcc_ctrl.sv =====
// Sequencer state machine and output word handshake for the controller.
module bcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bcc_pkg::cmd_t cmd_o
);
  import bcc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_FE_NUM;
      ST_FE_NUM:  state_d = ST_FE_MUL;
      ST_FE_MUL:  state_d = ST_FE_SET;
      ST_FE_SET:  state_d = ST_SI_SET;
      ST_SI_SET:  state_d = ST_SP_MUL2;
      ST_SP_MUL2: state_d = ST_SP_SUM;
      ST_SP_SUM:  state_d = ST_SP_SET;
      ST_SP_SET:  state_d = ST_D_SET;
      ST_D_SET:   state_d = ST_UP_MUL1;
      ST_UP_MUL1: state_d = ST_UP_MUL2;
      ST_UP_MUL2: state_d = ST_UP_SUM;
      ST_UP_SUM:  state_d = ST_UP_SET;
      ST_UP_SET:  state_d = ST_ST_MUL;
      ST_ST_MUL:  state_d = ST_ST_SET;
      ST_ST_SET:  state_d = ST_MIX;
      ST_MIX:     if (slot_free) state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_FE_NUM:  cmd_o.op = OP_FE_NUM;
      ST_FE_MUL:  cmd_o.op = OP_FE_MUL;
      ST_FE_SET:  cmd_o.op = OP_FE_SET;
      ST_SI_SET:  cmd_o.op = OP_SI_SET;
      ST_SP_MUL2: cmd_o.op = OP_SP_MUL2;
      ST_SP_SUM:  cmd_o.op = OP_SP_SUM;
      ST_SP_SET:  cmd_o.op = OP_SP_SET;
      ST_D_SET:   cmd_o.op = OP_D_SET;
      ST_UP_MUL1: cmd_o.op = OP_UP_MUL1;
      ST_UP_MUL2: cmd_o.op = OP_UP_MUL2;
      ST_UP_SUM:  cmd_o.op = OP_UP_SUM;
      ST_UP_SET:  cmd_o.op = OP_UP_SET;
      ST_ST_MUL:  cmd_o.op = OP_ST_MUL;
      ST_ST_SET:  cmd_o.op = OP_ST_SET;
      ST_MIX:     if (slot_free) cmd_o.op = OP_MIX;
    endcase
  end

  always_comb begin
    if (state_q == ST_MIX && slot_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_FE_NUM))
    else $error("accepted word did not start the sequence");

  a_valid_from_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_MIX))
    else $error("output valid raised outside the mix step");

  a_mix_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_MIX) |-> (!out_valid_q || out_ready_i))
    else $error("mix overwrote an output word not yet taken");

endmodule

// ===== rtl/bcc_dp.sv =====
// Datapath: mode select, velocity PI, upright PD, steering and mixing on one multiplier.
module bcc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcc_pkg::cmd_t      cmd_i,
  input  bcc_pkg::cfg_t      cfg_i,
  input  logic signed [15:0] enc_left_i,
  input  logic signed [15:0] enc_right_i,
  input  logic signed [16:0] pitch_i,
  input  logic signed [15:0] gyro_pitch_i,
  input  logic signed [15:0] gyro_yaw_i,
  input  logic               clear_integral_i,
  input  logic [1:0]         color_code_i,
  input  logic [15:0]        color_size_i,
  input  logic               line_usable_i,
  input  logic [7:0]         line_confidence_i,
  input  logic signed [15:0] line_error_i,
  input  logic signed [15:0] line_angle_i,
  output logic signed [15:0] motor_left_o,
  output logic signed [15:0] motor_right_o,
  output logic [1:0]         drive_mode_o,
  output logic signed [31:0] speed_term_o,
  output logic signed [31:0] upright_term_o,
  output logic signed [31:0] steer_term_o
);
  import bcc_pkg::*;

  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > Max32) r = Max32[31:0];
    else if (v < Min32) r = Min32[31:0];
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_lim(input logic signed [32:0] v,
                                                  input logic signed [32:0] lim);
    logic signed [32:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r[15:0];
  endfunction

  // tick state
  logic signed [17:0] fe_q, fe_d;
  logic signed [15:0] si_q, si_d;

  // captured word and working registers
  logic signed [17:0] err_q, err_d;
  logic signed [21:0] ln_q, ln_d;
  logic signed [16:0] pitch_q, pitch_d;
  logic signed [15:0] gpitch_q, gpitch_d, gyaw_q, gyaw_d;
  logic               clr_q, clr_d;
  drive_mode_e        mode_q, mode_d;
  logic signed [6:0]  turn_q, turn_d;
  logic signed [21:0] num_q, num_d;
  logic signed [63:0] prod_q, prod_d, acc_q, acc_d;
  logic signed [31:0] speed_q, speed_d, d_q, d_d, upright_q, upright_d, steer_q, steer_d;

  // output word
  logic signed [15:0] ml_q, ml_d, mr_q, mr_d;
  drive_mode_e        mode_out_q, mode_out_d;
  logic signed [31:0] speed_out_q, speed_out_d, up_out_q, up_out_d, st_out_q, st_out_d;

  // load decode
  logic               is_avoid, is_line;
  logic signed [4:0]  target;
  logic signed [6:0]  turn_sel;

  // helpers
  logic signed [21:0] num_mag, ln_mag;
  logic [13:0]        ln_abs;
  logic [17:0]        fe_quot;
  logic signed [18:0] si_sum;
  logic signed [63:0] sp_shift, up_shift, st_shift;
  logic signed [41:0] d_full;
  logic signed [31:0] st_lq;
  logic signed [32:0] lim33, ml_full, mr_full;
  logic signed [31:0] mul_a, mul_b;

  always_comb begin
    is_avoid = (color_code_i != COLOR_NONE) && (color_size_i >= AVOID_MIN_SIZE);
    is_line  = line_usable_i && (line_confidence_i >= LINE_MIN_CONF);
    turn_sel = TURN_OTHER;
    unique case (color_e'(color_code_i)) inside
      COLOR_LEFT:  turn_sel = -TURN_HARD;
      COLOR_RIGHT: turn_sel = TURN_HARD;
      COLOR_NONE, COLOR_OTHER: turn_sel = TURN_OTHER;
    endcase
    if (is_avoid) begin
      target = (color_code_i == COLOR_OTHER) ? TARGET_SLOW : TARGET_AVOID;
    end else if (is_line) begin
      target = TARGET_SLOW;
    end else begin
      target = TARGET_NONE;
    end
  end

  always_comb begin
    num_mag  = num_q[21] ? -num_q : num_q;
    ln_mag   = ln_q[21] ? -ln_q : ln_q;
    ln_abs   = (ln_mag > LINE_N_LIMIT) ? LINE_N_LIMIT[13:0] : ln_mag[13:0];
    fe_quot  = prod_q[24 +: 18];
    si_sum   = 19'(si_q) + 19'(fe_q);
    sp_shift = (acc_q + (acc_q[63] ? 64'sd65535 : 64'sd0)) >>> 16;
    up_shift = (acc_q + (acc_q[63] ? 64'sd16777215 : 64'sd0)) >>> 24;
    st_shift = (prod_q + (prod_q[63] ? 64'sd65535 : 64'sd0)) >>> 16;
    d_full   = 42'(pitch_q) - 42'(cfg_i.balance_angle) - (42'(speed_q) <<< 8);
    st_lq    = $signed(32'(prod_q[21 +: 7]));
    lim33    = $signed(33'(cfg_i.motor_limit));
    ml_full  = 33'(upright_q) - 33'(steer_q);
    mr_full  = 33'(upright_q) + 33'(steer_q);
  end

  always_comb begin
    fe_d = fe_q;  si_d = si_q;
    err_d = err_q;  ln_d = ln_q;  pitch_d = pitch_q;  gpitch_d = gpitch_q;  gyaw_d = gyaw_q;
    clr_d = clr_q;  mode_d = mode_q;  turn_d = turn_q;  num_d = num_q;
    acc_d = acc_q;  speed_d = speed_q;  d_d = d_q;  upright_d = upright_q;  steer_d = steer_q;
    ml_d = ml_q;  mr_d = mr_q;  mode_out_d = mode_out_q;
    speed_out_d = speed_out_q;  up_out_d = up_out_q;  st_out_d = st_out_q;
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_LOAD: begin
        err_d    = 18'(enc_left_i) + 18'(enc_right_i) - 18'(target);
        ln_d     = (22'(line_error_i) <<< 5) + (22'(line_angle_i) <<< 4)
                 + (22'(line_angle_i) <<< 1);
        pitch_d  = pitch_i;
        gpitch_d = gyro_pitch_i;
        gyaw_d   = gyro_yaw_i;
        clr_d    = clear_integral_i;
        turn_d   = turn_sel;
        mode_d   = is_avoid ? MODE_AVOID : (is_line ? MODE_LINE : MODE_BALANCE);
      end
      OP_FE_NUM: begin
        num_d = (22'(err_q) <<< 1) + 22'(err_q) + (22'(fe_q) <<< 3) - 22'(fe_q);
      end
      OP_FE_MUL: begin
        mul_a = $signed(32'(num_mag[20:0]));
        mul_b = RECIP_10;
      end
      OP_FE_SET: begin
        fe_d = num_q[21] ? -$signed(fe_quot) : $signed(fe_quot);
      end
      OP_SI_SET: begin
        if (clr_q) si_d = '0;
        else if (si_sum > 19'(INTEGRAL_LIMIT)) si_d = INTEGRAL_LIMIT;
        else if (si_sum < -19'(INTEGRAL_LIMIT)) si_d = -INTEGRAL_LIMIT;
        else si_d = si_sum[15:0];
        mul_a = cfg_i.speed_kp;
        mul_b = 32'(fe_q);
      end
      OP_SP_MUL2: begin
        acc_d = prod_q;
        mul_a = cfg_i.speed_ki;
        mul_b = 32'(si_q);
      end
      OP_SP_SUM:  acc_d = acc_q + prod_q;
      OP_SP_SET:  speed_d = sat32(sp_shift);
      OP_D_SET:   d_d = sat32(64'(d_full));
      OP_UP_MUL1: begin
        mul_a = cfg_i.upright_kp;
        mul_b = d_q;
      end
      OP_UP_MUL2: begin
        acc_d = prod_q;
        mul_a = cfg_i.upright_kd;
        mul_b = 32'(gpitch_q);
      end
      OP_UP_SUM:  acc_d = acc_q + (prod_q <<< 8);
      OP_UP_SET:  upright_d = sat32(up_shift);
      OP_ST_MUL: begin
        unique case (mode_q)
          MODE_AVOID: begin
            mul_a = cfg_i.steer_kp;
            mul_b = 32'(turn_q);
          end
          MODE_LINE: begin
            mul_a = $signed(32'(ln_abs));
            mul_b = RECIP_100;
          end
          default: begin
            mul_a = cfg_i.steer_damping;
            mul_b = 32'(gyaw_q);
          end
        endcase
      end
      OP_ST_SET: begin
        if (mode_q == MODE_LINE) steer_d = ln_q[21] ? -st_lq : st_lq;
        else steer_d = st_shift[31:0];
      end
      OP_MIX: begin
        ml_d        = clamp_lim(ml_full, lim33);
        mr_d        = clamp_lim(mr_full, lim33);
        mode_out_d  = mode_q;
        speed_out_d = speed_q;
        up_out_d    = upright_q;
        st_out_d    = steer_q;
      end
      default: ;
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q <= '0;
      si_q <= '0;
    end else begin
      fe_q <= fe_d;
      si_q <= si_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    ln_q        <= ln_d;
    pitch_q     <= pitch_d;
    gpitch_q    <= gpitch_d;
    gyaw_q      <= gyaw_d;
    clr_q       <= clr_d;
    mode_q      <= mode_d;
    turn_q      <= turn_d;
    num_q       <= num_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    speed_q     <= speed_d;
    d_q         <= d_d;
    upright_q   <= upright_d;
    steer_q     <= steer_d;
    ml_q        <= ml_d;
    mr_q        <= mr_d;
    mode_out_q  <= mode_out_d;
    speed_out_q <= speed_out_d;
    up_out_q    <= up_out_d;
    st_out_q    <= st_out_d;
  end

  assign motor_left_o   = ml_q;
  assign motor_right_o  = mr_q;
  assign drive_mode_o   = mode_out_q;
  assign speed_term_o   = speed_out_q;
  assign upright_term_o = up_out_q;
  assign steer_term_o   = st_out_q;

  a_integral_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (si_q <= INTEGRAL_LIMIT) && (si_q >= -INTEGRAL_LIMIT))
    else $error("speed integral outside its clamp");

  a_filter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fe_q <= 18'sd65546) && (fe_q >= -18'sd65546))
    else $error("filtered error outside input range");

  a_line_steer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MIX && mode_q == MODE_LINE) |-> (steer_q <= 32'sd100 && steer_q >= -32'sd100))
    else $error("line steering beyond its clamp");

endmodule

// ===== rtl/balance_cascade_controller_core.sv =====
// Top level of the cascaded balance controller: config regs, sequencer and datapath.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | in_valid_i / in_ready_o | encoders, pitch, gyro rates, vision fields
//  out     | out_valid_o/out_ready_i | motor drives, drive mode, loop terms
//  cfg     | cfg_we_i                | cfg_idx_i, cfg_wdata_i (no read-back)
//
// Each word passes through the accept cycle and then 15 sequencer steps that share
// one 32x32 signed multiplier (filter divide, PI, PD, steering, mix).
// in_ready_o is high only while the sequencer is idle.
// A finished word waits in the output register; a new word may be accepted meanwhile,
// and the final mix step holds until the output register is free.
// Reset restores register defaults and clears the filter and integral state.
module balance_cascade_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           enc_left_i,
  input  logic signed [15:0]           enc_right_i,
  input  logic signed [16:0]           pitch_i,
  input  logic signed [15:0]           gyro_pitch_i,
  input  logic signed [15:0]           gyro_yaw_i,
  input  logic                         clear_integral_i,
  input  logic [1:0]                   color_code_i,
  input  logic [15:0]                  color_size_i,
  input  logic                         line_usable_i,
  input  logic [7:0]                   line_confidence_i,
  input  logic signed [15:0]           line_error_i,
  input  logic signed [15:0]           line_angle_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           motor_left_o,
  output logic signed [15:0]           motor_right_o,
  output logic [1:0]                   drive_mode_o,
  output logic signed [31:0]           speed_term_o,
  output logic signed [31:0]           upright_term_o,
  output logic signed [31:0]           steer_term_o,
  input  logic                         cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bcc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bcc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  bcc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bcc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .enc_left_i        (enc_left_i),
    .enc_right_i       (enc_right_i),
    .pitch_i           (pitch_i),
    .gyro_pitch_i      (gyro_pitch_i),
    .gyro_yaw_i        (gyro_yaw_i),
    .clear_integral_i  (clear_integral_i),
    .color_code_i      (color_code_i),
    .color_size_i      (color_size_i),
    .line_usable_i     (line_usable_i),
    .line_confidence_i (line_confidence_i),
    .line_error_i      (line_error_i),
    .line_angle_i      (line_angle_i),
    .motor_left_o      (motor_left_o),
    .motor_right_o     (motor_right_o),
    .drive_mode_o      (drive_mode_o),
    .speed_term_o      (speed_term_o),
    .upright_term_o    (upright_term_o),
    .steer_term_o      (steer_term_o)
  );

endmodule
